FILE: rtl/core/mttmp_pkg.sv
package mttmp_pkg;

  // Address text is "hh:hh:hh:hh:hh:hh"
  localparam int unsigned TEXT_LEN_I = 17;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned CHAR_W     = 8;

  localparam logic [POS_W-1:0]  TEXT_LEN = POS_W'(TEXT_LEN_I);
  localparam logic [CHAR_W-1:0] COLON    = 8'h3A;
  localparam logic [ADDR_W-1:0] PREAMBLE = 48'hFFFF_FFFF_FFFF;

  // Digit decode: bit 4 set means the character is not a hex digit
  localparam logic [4:0] HEX_BAD = 5'h10;

  // Result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // One finished run handed from the parser to the packet emitter
  typedef struct packed {
    logic              err;
    logic [ADDR_W-1:0] addr;
  } job_t;

  // Decode one ASCII hex digit, either case
  function automatic logic [4:0] hex_value(input logic [CHAR_W-1:0] ch);
    logic [4:0] v;
    v = HEX_BAD;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      v = 5'(ch - 8'h30);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      v = 5'(ch - 8'h37);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      v = 5'(ch - 8'h57);
    end
    return v;
  endfunction

  // Separator slots sit after every digit pair but the last
  function automatic logic is_sep_pos(input logic [POS_W-1:0] pos);
    return (pos == 5'd2) || (pos == 5'd5) || (pos == 5'd8) ||
           (pos == 5'd11) || (pos == 5'd14);
  endfunction

endpackage

FILE: rtl/core/mac_text_to_magic_packet.sv
// Magic packet generator fed with the text form of a MAC address. Characters
// arrive on the in_ stream one per transfer, in_tlast on the final one, and the
// block takes one character every cycle while in_tready is high. On the final
// character a valid "hh:hh:hh:hh:hh:hh" text yields REPEATS+1 result words on the
// out_ stream, one per cycle while out_tready is high: an all-ones preamble word,
// then the address REPEATS times, out_tlast on the last. Any bad text yields one
// word of zero with out_tuser set and out_tlast set. The run is registered in the
// waiting slot, then in the emitter, then in the output register before its first
// word appears. Characters of the next text are taken while the packet is still
// going out; one finished run may wait behind the one being sent, and in_tready
// drops only when a further final character would need that waiting slot.
module mac_text_to_magic_packet
  import mttmp_pkg::*;
#(
  parameter int unsigned REPEATS = 16
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] address_char
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [47:0] packet_word
  output logic        out_tuser,  // [0] status
  output logic        out_tlast   // last_word
);

  localparam int unsigned CNT_W = $clog2(REPEATS + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(REPEATS);

  logic              in_fire;
  logic              parse_done;
  job_t              parse_job;

  logic              job_valid_r, job_valid_nxt;
  job_t              job_r;

  logic              em_active_r, em_active_nxt;
  logic              em_err_r;
  logic [ADDR_W-1:0] em_addr_r;
  logic [CNT_W-1:0]  em_cnt_r, em_cnt_nxt;
  logic              em_last;
  logic              em_take;
  logic              out_load;

  logic              out_tvalid_r, out_tvalid_nxt;
  logic [ADDR_W-1:0] out_tdata_r, out_word;
  logic              out_tuser_r;
  logic              out_tlast_r;

  // Hold off only a final character that finds the waiting slot still occupied
  assign in_tready = !job_valid_r || em_take || !in_tlast;
  assign in_fire   = in_tvalid && in_tready;

  mttmp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .char_fire (in_fire),
    .char_in   (in_tdata),
    .char_last (in_tlast),
    .job_valid (parse_done),
    .job       (parse_job)
  );

  // Emit one word whenever the output register is free
  always_comb begin
    out_load = em_active_r && (!out_tvalid_r || out_tready);
    em_last  = em_err_r || (em_cnt_r == LAST_CNT);
    em_take  = job_valid_r && (!em_active_r || (out_load && em_last));

    if (em_err_r) begin
      out_word = '0;
    end else if (em_cnt_r == '0) begin
      out_word = PREAMBLE;
    end else begin
      out_word = em_addr_r;
    end

    em_active_nxt = em_active_r;
    em_cnt_nxt    = em_cnt_r;
    if (out_load) begin
      if (em_last) begin
        em_active_nxt = 1'b0;
      end else begin
        em_cnt_nxt = em_cnt_r + 1'b1;
      end
    end
    if (em_take) begin
      em_active_nxt = 1'b1;
      em_cnt_nxt    = '0;
    end

    job_valid_nxt = job_valid_r;
    if (em_take) job_valid_nxt = 1'b0;
    if (parse_done) job_valid_nxt = 1'b1;

    out_tvalid_nxt = out_tvalid_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r  <= 1'b0;
      em_active_r  <= 1'b0;
      em_cnt_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      job_valid_r  <= job_valid_nxt;
      em_active_r  <= em_active_nxt;
      em_cnt_r     <= em_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload: pending run, run being sent, result word
  always_ff @(posedge clk) begin
    if (parse_done) job_r <= parse_job;
    if (em_take) begin
      em_err_r  <= job_r.err;
      em_addr_r <= job_r.addr;
    end
    if (out_load) begin
      out_tdata_r <= out_word;
      out_tuser_r <= em_err_r ? STATUS_FAIL : STATUS_OK;
      out_tlast_r <= em_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

`ifndef SYNTHESIS
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == '0))
    else $error("error result not a single zero word");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    em_active_r |-> em_cnt_r <= LAST_CNT)
    else $error("word count past repeat count");

  a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r && !em_take |=> job_valid_r)
    else $error("pending run lost");

  a_job_taken: assert property (@(posedge clk) disable iff (!rst_n)
    parse_done |=> job_valid_r)
    else $error("finished run not captured");

  a_preamble_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && !em_err_r && (em_cnt_r == '0) |=> out_tdata == PREAMBLE)
    else $error("packet does not open with preamble");
`endif

endmodule

FILE: rtl/core/mttmp_parse.sv
module mttmp_parse
  import mttmp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              char_fire,
  input  logic [CHAR_W-1:0] char_in,
  input  logic              char_last,
  output logic              job_valid,
  output job_t              job
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [ADDR_W-1:0] shift_r, shift_nxt;
  logic              fail_r, fail_nxt;
  logic [4:0]        digit;

  // Check one character against its slot and fold it into the address
  always_comb begin
    digit     = hex_value(char_in);
    pos_nxt   = pos_r;
    shift_nxt = shift_r;
    fail_nxt  = fail_r;
    if (pos_r >= TEXT_LEN) begin
      fail_nxt = 1'b1;
      pos_nxt  = TEXT_LEN;
    end else begin
      if (is_sep_pos(pos_r)) begin
        if (char_in != COLON) fail_nxt = 1'b1;
      end else if (digit[4]) begin
        fail_nxt = 1'b1;
      end else begin
        shift_nxt = {shift_r[ADDR_W-5:0], digit[3:0]};
      end
      pos_nxt = pos_r + 5'd1;
    end
  end

  // Hand the run over on the final character
  assign job_valid = char_fire && char_last;
  assign job.err   = fail_nxt || (pos_nxt != TEXT_LEN);
  assign job.addr  = shift_nxt;

  // Advance parse state; restart after the final character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      fail_r <= 1'b0;
    end else if (char_fire) begin
      if (char_last) begin
        pos_r  <= '0;
        fail_r <= 1'b0;
      end else begin
        pos_r  <= pos_nxt;
        fail_r <= fail_nxt;
      end
    end
  end

  // Address digits need no reset: a good run overwrites all of them
  always_ff @(posedge clk) begin
    if (char_fire) shift_r <= shift_nxt;
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= TEXT_LEN)
    else $error("parse position past text length");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    char_fire && char_last |=> (pos_r == '0) && !fail_r)
    else $error("parser did not restart after final character");

  a_overlength: assert property (@(posedge clk) disable iff (!rst_n)
    char_fire && !char_last && (pos_r == TEXT_LEN) |=> fail_r && (pos_r == TEXT_LEN))
    else $error("overlength text not flagged");

  a_short_fails: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && (pos_r < 5'd16) |-> job.err)
    else $error("short text not flagged");
`endif

endmodule
